### rtl/rlps_pkg.sv
// Shared types, constants and helpers for the run list pixel scatter block.
// No dependencies; rlps_front, rlps_back and run_list_pixel_scatter import this package.
package rlps_pkg;

   localparam int IMAGE_PIXELS = 1048576;
   localparam int MAX_RUNS     = 2048;
   localparam int QUEUE_DEPTH  = 4;

   localparam int PIX_AW   = $clog2(IMAGE_PIXELS);
   localparam int RUN_AW   = $clog2(MAX_RUNS);
   localparam int RUN_CW   = $clog2(MAX_RUNS + 1);
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   localparam int PIDX_W  = 20;
   localparam int START_W = 20;
   localparam int EXTRA_W = 16;
   localparam int DATA_W  = 16;
   localparam int PIX_W   = START_W + 1;
   localparam int RUN_W   = START_W + EXTRA_W;

   localparam logic [DATA_W-1:0] BLANK_RESET = 16'h8000;

   localparam logic [2:0] FUNC_CLEAR  = 3'd0;
   localparam logic [2:0] FUNC_APPEND = 3'd1;
   localparam logic [2:0] FUNC_FRAME  = 3'd2;
   localparam logic [2:0] FUNC_SAMPLE = 3'd3;
   localparam logic [2:0] FUNC_READ   = 3'd4;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd3;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_CLEAR,
      OP_APPEND,
      OP_FRAME,
      OP_SAMPLE,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [START_W-1:0]        run_start;
      logic [EXTRA_W-1:0]        run_extra;
      logic signed [DATA_W-1:0]  sample_value;
      logic [PIDX_W-1:0]         pixel_index;
      logic                      in_image;
   } cmd_type;

   typedef struct packed {
      logic [START_W-1:0] run_start;
      logic [EXTRA_W-1:0] run_extra;
   } run_type;

   function automatic logic pix_in_image(input logic [PIX_W-1:0] pix);
      return 32'(pix) < 32'(IMAGE_PIXELS);
   endfunction

endpackage

### rtl/rlps_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rlps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rlps_front.sv
// Request front end: accepts words, decodes func into a command and queues it.
// Depends on rlps_pkg.
module rlps_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_func,
   input  logic [rlps_pkg::START_W-1:0]     req_run_start,
   input  logic [rlps_pkg::EXTRA_W-1:0]     req_run_extra,
   input  logic signed [rlps_pkg::DATA_W-1:0] req_sample_value,
   input  logic [rlps_pkg::PIDX_W-1:0]      req_pixel_index,
   input  logic                             fill_busy,
   output rlps_pkg::cmd_type                head,
   output logic                             head_valid,
   input  logic                             head_pop
);
   import rlps_pkg::*;

   cmd_type             cmd;
   cmd_type             que_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                push;
   logic                full;

   always_comb begin
      case (req_func)
         FUNC_CLEAR:  cmd.op = OP_CLEAR;
         FUNC_APPEND: cmd.op = OP_APPEND;
         FUNC_FRAME:  cmd.op = OP_FRAME;
         FUNC_SAMPLE: cmd.op = OP_SAMPLE;
         FUNC_READ:   cmd.op = OP_READ;
         default:     cmd.op = OP_NOP;
      endcase
      cmd.run_start    = req_run_start;
      cmd.run_extra    = req_run_extra;
      cmd.sample_value = req_sample_value;
      cmd.pixel_index  = req_pixel_index;
      cmd.in_image     = pix_in_image(PIX_W'(req_pixel_index));
   end

   assign full       = count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH);
   assign req_ready  = !full && !fill_busy;
   assign push       = req_valid && req_ready;
   assign head_valid = count_ff != '0;
   assign head       = que_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, head_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         que_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

### rtl/rlps_back.sv
// Execution back end: run table, cursor, image store, fill sweep and result word.
// Depends on rlps_pkg and rlps_ram.
module rlps_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic signed [rlps_pkg::DATA_W-1:0] csr_blank_value,
   input  rlps_pkg::cmd_type                  head,
   input  logic                               head_valid,
   output logic                               head_pop,
   output logic                               fill_busy,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [rlps_pkg::DATA_W-1:0] rsp_read_value,
   output logic [1:0]                         rsp_status
);
   import rlps_pkg::*;

   typedef enum logic [2:0] {
      ST_FILL = 3'b001,
      ST_RUN  = 3'b010,
      ST_PEEK = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [PIX_AW-1:0]   fill_addr_ff, fill_addr_in;
   logic [DATA_W-1:0]   fill_value_ff, fill_value_in;
   logic [DATA_W-1:0]   blank_ff;
   logic [RUN_CW-1:0]   run_count_ff, run_count_in;
   logic [RUN_CW-1:0]   cursor_run_ff, cursor_run_in;
   logic [EXTRA_W-1:0]  offset_ff, offset_in;
   logic                cache_ok_ff, cache_ok_in;
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic                load_rsp;
   logic                out_free;
   logic [RUN_CW-1:0]   next_run;
   logic [PIX_W-1:0]    pix;

   logic                tbl_we, tbl_re;
   logic [RUN_AW-1:0]   tbl_raddr;
   run_type             tbl_wdata, tbl_rdata;
   logic                img_we, img_re;
   logic [PIX_AW-1:0]   img_waddr;
   logic [DATA_W-1:0]   img_wdata, img_rdata;

   assign tbl_wdata.run_start = head.run_start;
   assign tbl_wdata.run_extra = head.run_extra;

   rlps_ram #(.WIDTH(RUN_W), .DEPTH(MAX_RUNS)) u_run_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (run_count_ff[RUN_AW-1:0]),
      .wr_data (tbl_wdata),
      .rd_en   (tbl_re),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   rlps_ram #(.WIDTH(DATA_W), .DEPTH(IMAGE_PIXELS)) u_image (
      .clock   (clock),
      .wr_en   (img_we),
      .wr_addr (img_waddr),
      .wr_data (img_wdata),
      .rd_en   (img_re),
      .rd_addr (PIX_AW'(head.pixel_index)),
      .rd_data (img_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign next_run  = cursor_run_ff + 1'b1;
   assign pix       = PIX_W'(tbl_rdata.run_start) + PIX_W'(offset_ff);
   assign fill_busy = state_ff == ST_FILL;

   always_comb begin
      state_in      = state_ff;
      fill_addr_in  = fill_addr_ff;
      fill_value_in = fill_value_ff;
      run_count_in  = run_count_ff;
      cursor_run_in = cursor_run_ff;
      offset_in     = offset_ff;
      cache_ok_in   = cache_ok_ff;
      rsp_value_in  = '0;
      rsp_status_in = STATUS_OK;
      load_rsp      = 1'b0;
      head_pop      = 1'b0;
      tbl_we        = 1'b0;
      tbl_re        = 1'b0;
      tbl_raddr     = cursor_run_ff[RUN_AW-1:0];
      img_we        = 1'b0;
      img_re        = 1'b0;
      img_waddr     = PIX_AW'(pix);
      img_wdata     = head.sample_value;

      case (state_ff)
         ST_FILL: begin
            img_we       = 1'b1;
            img_waddr    = fill_addr_ff;
            img_wdata    = fill_value_ff;
            fill_addr_in = fill_addr_ff + 1'b1;
            if (fill_addr_ff == PIX_AW'(IMAGE_PIXELS - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (head_valid) begin
               case (head.op)
                  OP_CLEAR: begin
                     if (out_free) begin
                        head_pop      = 1'b1;
                        load_rsp      = 1'b1;
                        run_count_in  = '0;
                        cursor_run_in = '0;
                        offset_in     = '0;
                        cache_ok_in   = 1'b0;
                     end
                  end
                  OP_APPEND: begin
                     if (out_free) begin
                        head_pop = 1'b1;
                        load_rsp = 1'b1;
                        if (run_count_ff == RUN_CW'(MAX_RUNS)) begin
                           rsp_status_in = STATUS_FULL;
                        end else begin
                           tbl_we       = 1'b1;
                           run_count_in = run_count_ff + 1'b1;
                        end
                     end
                  end
                  OP_FRAME: begin
                     if (out_free) begin
                        head_pop      = 1'b1;
                        load_rsp      = 1'b1;
                        cursor_run_in = '0;
                        offset_in     = '0;
                        tbl_re        = 1'b1;
                        tbl_raddr     = '0;
                        cache_ok_in   = run_count_ff != '0;
                        fill_value_in = blank_ff;
                        fill_addr_in  = '0;
                        state_in      = ST_FILL;
                     end
                  end
                  OP_SAMPLE: begin
                     if (cursor_run_ff >= run_count_ff) begin
                        if (out_free) begin
                           head_pop      = 1'b1;
                           load_rsp      = 1'b1;
                           rsp_status_in = STATUS_DROPPED;
                        end
                     end else if (!cache_ok_ff) begin
                        tbl_re      = 1'b1;
                        cache_ok_in = 1'b1;
                     end else if (out_free) begin
                        head_pop = 1'b1;
                        load_rsp = 1'b1;
                        if (pix_in_image(pix)) begin
                           img_we = 1'b1;
                        end else begin
                           rsp_status_in = STATUS_OUTSIDE;
                        end
                        if (offset_ff >= tbl_rdata.run_extra) begin
                           offset_in     = '0;
                           cursor_run_in = next_run;
                           tbl_re        = 1'b1;
                           tbl_raddr     = next_run[RUN_AW-1:0];
                           cache_ok_in   = next_run < run_count_ff;
                        end else begin
                           offset_in = offset_ff + 1'b1;
                        end
                     end
                  end
                  OP_READ: begin
                     if (out_free) begin
                        head_pop = 1'b1;
                        if (head.in_image) begin
                           img_re   = 1'b1;
                           state_in = ST_PEEK;
                        end else begin
                           load_rsp      = 1'b1;
                           rsp_status_in = STATUS_OUTSIDE;
                        end
                     end
                  end
                  default: begin
                     if (out_free) begin
                        head_pop = 1'b1;
                        load_rsp = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_PEEK: begin
            if (out_free) begin
               load_rsp     = 1'b1;
               rsp_value_in = img_rdata;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         fill_addr_ff  <= '0;
         fill_value_ff <= BLANK_RESET;
         blank_ff      <= BLANK_RESET;
         run_count_ff  <= '0;
         cursor_run_ff <= '0;
         offset_ff     <= '0;
         cache_ok_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_addr_ff  <= fill_addr_in;
         fill_value_ff <= fill_value_in;
         run_count_ff  <= run_count_in;
         cursor_run_ff <= cursor_run_in;
         offset_ff     <= offset_in;
         cache_ok_ff   <= cache_ok_in;
         if (csr_we) begin
            blank_ff <= csr_blank_value;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

### rtl/run_list_pixel_scatter.sv
// Run list pixel scatter: places a sample stream into a 1M pixel image at the
// pixels listed by a table of runs (start, extra), and reads pixels back. Each
// request word produces one response word. Samples execute one per cycle while
// the current run's table entry is cached and the response register is free; the
// first sample after a run change that missed the prefetch waits for a table
// RAM read. A pixel read passes through a peek state for the registered image
// RAM read. A frame start, and reset, sweep the whole image RAM with the blank
// value through its single write port. During that sweep req_ready is low; csr
// writes are taken at any time, and a blank value change takes effect at the next
// frame start. Up to four request words queue ahead of execution. Depends on
// rlps_pkg, rlps_front, rlps_back.
module run_list_pixel_scatter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic signed [rlps_pkg::DATA_W-1:0] csr_blank_value,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_func,
   input  logic [rlps_pkg::START_W-1:0]       req_run_start,
   input  logic [rlps_pkg::EXTRA_W-1:0]       req_run_extra,
   input  logic signed [rlps_pkg::DATA_W-1:0] req_sample_value,
   input  logic [rlps_pkg::PIDX_W-1:0]        req_pixel_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [rlps_pkg::DATA_W-1:0] rsp_read_value,
   output logic [1:0]                         rsp_status
);
   import rlps_pkg::*;

   cmd_type head;
   logic    head_valid;
   logic    head_pop;
   logic    fill_busy;

   assign csr_ready = 1'b1;

   rlps_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_run_start    (req_run_start),
      .req_run_extra    (req_run_extra),
      .req_sample_value (req_sample_value),
      .req_pixel_index  (req_pixel_index),
      .fill_busy        (fill_busy),
      .head             (head),
      .head_valid       (head_valid),
      .head_pop         (head_pop)
   );

   rlps_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_valid && csr_ready),
      .csr_blank_value (csr_blank_value),
      .head            (head),
      .head_valid      (head_valid),
      .head_pop        (head_pop),
      .fill_busy       (fill_busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status)
   );

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("queue popped while empty");

   a_full_has_head: assert property (@(posedge clock) disable iff (reset)
      (!req_ready && !fill_busy) |-> head_valid)
      else $error("request stalled with empty queue");

   a_error_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> rsp_read_value == '0)
      else $error("error response carries nonzero value");

   a_no_pop_in_fill: assert property (@(posedge clock) disable iff (reset)
      fill_busy |-> !head_pop)
      else $error("command executed during fill sweep");

endmodule

### dv/run_list_pixel_scatter_tb.sv
// Testbench for run_list_pixel_scatter: directed rows, then random run lists,
// sample streams and reads, checked word by word against an in-bench predictor.
// Depends on rlps_pkg and the run_list_pixel_scatter RTL.
`timescale 1ns / 100ps

module run_list_pixel_scatter_tb;
   import rlps_pkg::*;

   localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
   localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
   localparam logic signed [DATA_W-1:0] BLANK_MAX = 16'sh7FFF;
   localparam logic signed [DATA_W-1:0] BLANK_MIN = 16'sh8000;
   localparam int unsigned CYCLE_LIMIT = 20_000_000;
   localparam int STALL_CYCLES = 400;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [1:0]               status;
   } scatter_word_type;

   typedef struct packed {
      logic [2:0]               func;
      logic [START_W-1:0]       run_start;
      logic [EXTRA_W-1:0]       run_extra;
      logic signed [DATA_W-1:0] sample_value;
      logic [PIDX_W-1:0]        pixel_index;
      bit                       typed;
      logic signed [DATA_W-1:0] want_value;
      logic [1:0]               want_status;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic signed [DATA_W-1:0]  csr_blank_value = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [2:0]                req_func = FUNC_CLEAR;
   logic [START_W-1:0]        req_run_start = '0;
   logic [EXTRA_W-1:0]        req_run_extra = '0;
   logic signed [DATA_W-1:0]  req_sample_value = '0;
   logic [PIDX_W-1:0]         req_pixel_index = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [DATA_W-1:0]  rsp_read_value;
   logic [1:0]                rsp_status;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int          fail_count = 0;
   bit          stall_req = 1'b0;
   bit          stall_seen = 1'b0;
   int          stall_left = 0;

   scatter_word_type scatter_results[$];
   stim_row_type     directed_rows[$];

   // predictor state
   logic signed [DATA_W-1:0] blank_reg = BLANK_RESET;
   logic signed [DATA_W-1:0] frame_blank = BLANK_RESET;
   logic [START_W-1:0]       run_first [MAX_RUNS];
   logic [EXTRA_W-1:0]       run_more [MAX_RUNS];
   int unsigned              run_total = 0;
   int unsigned              cur_run = 0;
   int unsigned              cur_off = 0;
   logic signed [DATA_W-1:0] written_pix [int unsigned];

   run_list_pixel_scatter dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_blank_value  (csr_blank_value),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_run_start    (req_run_start),
      .req_run_extra    (req_run_extra),
      .req_sample_value (req_sample_value),
      .req_pixel_index  (req_pixel_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status)
   );

   always #5 clock = ~clock;

   function automatic scatter_word_type scatter_step(
      input logic [2:0]               f,
      input logic [START_W-1:0]       rs,
      input logic [EXTRA_W-1:0]       re,
      input logic signed [DATA_W-1:0] sv,
      input logic [PIDX_W-1:0]        pi
   );
      scatter_word_type w;
      int unsigned      pix;
      w = '0;
      case (f)
         FUNC_CLEAR: begin
            run_total = 0;
            cur_run = 0;
            cur_off = 0;
         end
         FUNC_APPEND: begin
            if (run_total >= MAX_RUNS) begin
               w.status = STATUS_FULL;
            end else begin
               run_first[run_total] = rs;
               run_more[run_total] = re;
               run_total++;
            end
         end
         FUNC_FRAME: begin
            written_pix.delete();
            frame_blank = blank_reg;
            cur_run = 0;
            cur_off = 0;
         end
         FUNC_SAMPLE: begin
            if (cur_run >= run_total) begin
               w.status = STATUS_DROPPED;
            end else begin
               pix = run_first[cur_run] + cur_off;
               if (pix < IMAGE_PIXELS) written_pix[pix] = sv;
               else w.status = STATUS_OUTSIDE;
               if (cur_off >= run_more[cur_run]) begin
                  cur_off = 0;
                  cur_run++;
               end else begin
                  cur_off++;
               end
            end
         end
         FUNC_READ: begin
            if (pi < IMAGE_PIXELS) begin
               w.read_value = written_pix.exists(pi) ? written_pix[pi] : frame_blank;
            end else begin
               w.status = STATUS_OUTSIDE;
            end
         end
         default: ;
      endcase
      return w;
   endfunction

   function automatic void row(
      input logic [2:0]               f,
      input logic [START_W-1:0]       rs,
      input logic [EXTRA_W-1:0]       re,
      input logic signed [DATA_W-1:0] sv,
      input logic [PIDX_W-1:0]        pi,
      input bit                       typed = 1'b0,
      input logic signed [DATA_W-1:0] tv = '0,
      input logic [1:0]               ts = STATUS_OK
   );
      stim_row_type r;
      r = '{f, rs, re, sv, pi, typed, tv, ts};
      directed_rows.push_back(r);
   endfunction

   task automatic send_word(
      input logic [2:0]               f,
      input logic [START_W-1:0]       rs,
      input logic [EXTRA_W-1:0]       re,
      input logic signed [DATA_W-1:0] sv,
      input logic [PIDX_W-1:0]        pi,
      input bit                       typed = 1'b0,
      input logic signed [DATA_W-1:0] tv = '0,
      input logic [1:0]               ts = STATUS_OK
   );
      scatter_word_type w;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_run_start <= rs;
      req_run_extra <= re;
      req_sample_value <= sv;
      req_pixel_index <= pi;
      do @(posedge clock); while (!req_ready);
      w = scatter_step(f, rs, re, sv, pi);
      if (typed) begin
         w.read_value = tv;
         w.status = ts;
      end
      scatter_results.push_back(w);
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      while (scatter_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_blank(input logic signed [DATA_W-1:0] v);
      csr_valid <= 1'b1;
      csr_blank_value <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      blank_reg = v;
   endtask

   task automatic random_items(input int quota);
      logic [START_W-1:0] seq_start [8];
      logic [EXTRA_W-1:0] seq_extra [8];
      logic [2:0]         f;
      int                 nruns;
      int                 span;
      int                 nsamp;
      int                 k;
      int                 done;
      done = 0;
      while (done < quota) begin
         if ($urandom_range(9) < 8) begin
            send_word(FUNC_CLEAR, 20'($urandom), 16'($urandom), 16'($urandom), 20'($urandom));
            nruns = $urandom_range(8, 1);
            span = 0;
            for (int i = 0; i < nruns; i++) begin
               case ($urandom_range(9))
                  0, 1: seq_start[i] = 20'hFFFFF - 20'($urandom_range(6));
                  2: seq_start[i] = 20'($urandom_range(40));
                  default: seq_start[i] = 20'($urandom);
               endcase
               if ($urandom_range(19) == 0) seq_extra[i] = 16'($urandom_range(60));
               else seq_extra[i] = 16'($urandom_range(5));
               span += int'(seq_extra[i]) + 1;
               send_word(FUNC_APPEND, seq_start[i], seq_extra[i], 16'($urandom),
                         20'($urandom));
            end
            done += nruns + 1;
            nsamp = span + $urandom_range(3);
            for (int i = 0; i < nsamp; i++) begin
               if ($urandom_range(7) == 0) begin
                  k = $urandom_range(nruns - 1);
                  send_word(FUNC_READ, 20'($urandom), 16'($urandom), 16'($urandom),
                            20'(seq_start[k] + $urandom_range(seq_extra[k])));
                  done++;
               end
               send_word(FUNC_SAMPLE, 20'($urandom), 16'($urandom), 16'($urandom),
                         20'($urandom));
               done++;
            end
            for (int i = 0; i < 3; i++) begin
               k = $urandom_range(nruns - 1);
               send_word(FUNC_READ, 20'($urandom), 16'($urandom), 16'($urandom),
                         20'(seq_start[k] + $urandom_range(seq_extra[k])));
            end
            done += 3;
         end else begin
            f = 3'($urandom_range(7));
            if (f == FUNC_FRAME) f = FUNC_SAMPLE;
            send_word(f, 20'($urandom), 16'($urandom), 16'($urandom), 20'($urandom));
            if (!(f inside {FUNC_SPARE_5, FUNC_SPARE_6, FUNC_SPARE_7})) done++;
         end
      end
   endtask

   always @(posedge clock) begin : rsp_side
      scatter_word_type want;
      if (stall_req != stall_seen) begin
         stall_seen = stall_req;
         stall_left = STALL_CYCLES;
      end else if (stall_left != 0) begin
         stall_left--;
      end
      rsp_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (scatter_results.size() == 0) begin
            $error("unexpected response word: read_value %0d status %0d",
                   rsp_read_value, rsp_status);
            fail_count++;
         end else begin
            want = scatter_results.pop_front();
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d",
                      $signed(want.read_value), rsp_read_value);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL run_list_pixel_scatter");
      $finish;
   end

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_blank(BLANK_MAX);

      row(FUNC_READ, '0, '0, '0, '0, 1'b1, BLANK_RESET, STATUS_OK);
      row(FUNC_READ, '0, '0, '0, '1, 1'b1, BLANK_RESET, STATUS_OK);
      row(FUNC_SAMPLE, '0, '0, 16'sh1234, '0, 1'b1, '0, STATUS_DROPPED);
      row(FUNC_SPARE_5, '0, '0, '0, '0, 1'b1, '0, STATUS_OK);
      row(FUNC_SPARE_6, '1, '1, '1, '1, 1'b1, '0, STATUS_OK);
      row(FUNC_SPARE_7, '1, '1, '1, '1, 1'b1, '0, STATUS_OK);
      row(FUNC_APPEND, 20'd3, '0, '0, '0, 1'b1, '0, STATUS_OK);
      row(FUNC_FRAME, '0, '0, '0, '0, 1'b1, '0, STATUS_OK);
      row(FUNC_READ, '0, '0, '0, 20'd12345, 1'b1, BLANK_MAX, STATUS_OK);
      row(FUNC_APPEND, 20'hFFFFF, 16'd1, '0, '0, 1'b1, '0, STATUS_OK);
      row(FUNC_APPEND, '0, 16'd2, '0, '0, 1'b1, '0, STATUS_OK);
      row(FUNC_SAMPLE, '0, '0, 16'sh0000, '0, 1'b1, '0, STATUS_OK);
      row(FUNC_SAMPLE, '0, '0, BLANK_MIN, '0, 1'b1, '0, STATUS_OK);
      row(FUNC_SAMPLE, '0, '0, BLANK_MAX, '0, 1'b1, '0, STATUS_OUTSIDE);
      row(FUNC_SAMPLE, '0, '0, 16'sh5A5A, '0);
      row(FUNC_SAMPLE, '0, '0, 16'shA5A5, '0);
      row(FUNC_SAMPLE, '0, '0, -16'sd1, '0);
      row(FUNC_SAMPLE, '0, '0, 16'sh0101, '0, 1'b1, '0, STATUS_DROPPED);
      row(FUNC_READ, '0, '0, '0, 20'd3, 1'b1, '0, STATUS_OK);
      row(FUNC_READ, '0, '0, '0, 20'hFFFFF, 1'b1, BLANK_MIN, STATUS_OK);
      row(FUNC_READ, '0, '0, '0, 20'd1);
      row(FUNC_CLEAR, '0, '0, '0, '0, 1'b1, '0, STATUS_OK);
      row(FUNC_SAMPLE, '0, '0, 16'sh7777, '0, 1'b1, '0, STATUS_DROPPED);
      row(FUNC_APPEND, 20'hFFF00, 16'hFFFF, '0, '0, 1'b1, '0, STATUS_OK);
      row(FUNC_SAMPLE, '0, '0, 16'sh0F0F, '0);
      row(FUNC_READ, '0, '0, '0, 20'hFFF00);
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].func, directed_rows[i].run_start,
                   directed_rows[i].run_extra, directed_rows[i].sample_value,
                   directed_rows[i].pixel_index, directed_rows[i].typed,
                   directed_rows[i].want_value, directed_rows[i].want_status);
      end

      drain_words();
      write_blank(BLANK_MIN);
      send_idle_pct = 29;
      recv_idle_pct = 81;
      send_word(FUNC_FRAME, '0, '0, '0, '0);
      random_items(120);

      // blank change only shows after the next frame start
      drain_words();
      write_blank(16'($urandom));
      send_idle_pct = 81;
      recv_idle_pct = 29;
      random_items(120);

      drain_words();
      write_blank(16'sd0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_word(FUNC_FRAME, '0, '0, '0, '0);
      send_word(FUNC_CLEAR, '0, '0, '0, '0);
      for (int i = 0; i < MAX_RUNS + 3; i++) begin
         send_word(FUNC_APPEND, 20'($urandom), 16'($urandom_range(2)), 16'($urandom),
                   20'($urandom));
      end
      stall_req = ~stall_req;
      for (int i = 0; i < 80; i++) begin
         send_word(FUNC_SAMPLE, 20'($urandom), 16'($urandom), 16'($urandom), 20'($urandom));
         if ($urandom_range(3) == 0) begin
            send_word(FUNC_READ, 20'($urandom), 16'($urandom), 16'($urandom),
                      20'($urandom));
         end
      end
      random_items(40);

      drain_words();
      repeat (16) @(posedge clock);
      if (fail_count == 0 && scatter_results.size() == 0) begin
         $display("PASS run_list_pixel_scatter");
      end else begin
         $display("FAIL run_list_pixel_scatter");
      end
      $finish;
   end

endmodule
